// File: sv/wnf_pkg.sv
// ============================================================================
// wnf_pkg - shared types and constants for the wildcard name filter
// Beat structs, operation/kind/filter codes, character constants, case fold.
// ============================================================================
`default_nettype none

package wnf_pkg;

    // operation codes
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_NAME    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // type_filter codes
    localparam logic [1:0] FILT_ALL  = 2'd0;
    localparam logic [1:0] FILT_FILE = 2'd1;
    localparam logic [1:0] FILT_DIR  = 2'd2;

    // entry_kind codes
    localparam logic [1:0] KIND_FILE = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;

    // dot prefix tracking
    localparam logic [1:0] DOT_EMPTY = 2'd0;
    localparam logic [1:0] DOT_ONE   = 2'd1;
    localparam logic [1:0] DOT_TWO   = 2'd2;
    localparam logic [1:0] DOT_OTHER = 2'd3;

    // register index (paddr bit 2)
    localparam logic REG_TYPE_FILTER = 1'b0;

    localparam logic [1:0] TYPE_FILTER_RESET = FILT_FILE;

    // characters
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_value;
        logic       last;
        logic [1:0] entry_kind;
    } in_beat_t;

    typedef struct packed {
        logic name_matches;
        logic entry_accepted;
        logic pattern_overflow;
    } out_beat_t;

    // hand-off between neighboring cells
    typedef struct packed {
        logic fwd;   // previous cell consumed the byte, activates this one
        logic carry; // star closure from previous cell
    } link_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
            return c - CASE_OFS;
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/wnf_cell.sv
// ============================================================================
// wnf_cell - one pattern position
// Holds one pattern byte, steps its active bit per name byte, and ripples the
// star closure on to the next cell.
// ============================================================================
`default_nettype none

module wnf_cell import wnf_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       we,
    input  wire logic [7:0] wdata,
    input  wire logic [7:0] sym,      // folded name byte
    input  wire logic       act,      // position active before this byte
    input  wire logic       used,     // position lies inside the pattern
    input  wire link_t      link_in,
    output link_t           link_out,
    output logic            fin       // position active after this byte
);

    logic [7:0] p_reg;
    logic       is_star;
    logic       hit;
    logic       live;

    always_ff @(posedge aclk) begin
        if (we) begin
            p_reg <= wdata;
        end
    end

    assign is_star = (p_reg == CH_STAR);
    assign hit     = (p_reg == CH_QMARK) || (fold_case(p_reg) == sym);
    assign live    = act & used;

    // star keeps itself active; neighbor hit or closure activates us
    assign fin            = link_in.fwd | link_in.carry | (live & is_star);
    assign link_out.fwd   = live & ~is_star & hit;
    assign link_out.carry = fin & used & is_star;

endmodule

`default_nettype wire

// File: sv/wnf_out_buf.sv
// ============================================================================
// wnf_out_buf - result output register with skid stage
// Two-entry buffer so the input side keeps moving while a result waits.
// ============================================================================
`default_nettype none

module wnf_out_buf import wnf_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire out_beat_t push_data,
    output logic           can_push,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    logic      out_v_reg;
    logic      skid_v_reg;
    out_beat_t out_d_reg;
    out_beat_t skid_d_reg;
    logic      pop;

    assign pop      = out_v_reg & m_ready;
    assign can_push = ~skid_v_reg;
    assign m_valid  = out_v_reg;
    assign m_data   = out_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (pop) begin
                out_d_reg  <= skid_d_reg;
                skid_v_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_v_reg || pop) begin
                out_d_reg <= push_data;
                out_v_reg <= 1'b1;
            end else begin
                skid_d_reg <= push_data;
                skid_v_reg <= 1'b1;
            end
        end else if (pop) begin
            out_v_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: sv/wildcard_name_filter.sv
// ============================================================================
// wildcard_name_filter - case-insensitive glob match of directory entry names
// Pattern load, bit-parallel name matching, dot and entry-kind filtering.
// ============================================================================
// Takes one beat per cycle while s_ready is high, pattern bytes and name
// bytes alike: each name byte updates the set of active pattern positions
// through a row of PATTERN_DEPTH cells, one per pattern byte, with the
// star closure rippling from cell to cell like a carry chain. The result
// for a name is registered in the output buffer when its last byte is
// taken; a two-entry output buffer lets input beats keep flowing while
// a result waits, and s_ready drops only when both entries are full. '?'
// matches one byte, '*' zero or more, a-z fold to upper case. A pattern beat
// after a pattern's last byte (or after a clear) starts a new pattern; bytes
// beyond PATTERN_DEPTH are dropped and reported as pattern_overflow. Pattern
// and clear beats abandon a name in progress. entry_accepted also needs the
// name not to be "." or ".." and its kind to pass type_filter (APB address
// 0: 0 all, 1 regular files, 2 directories, 3 none; reset 1). No clearing
// pass is needed after reset.
// ============================================================================
`default_nettype none

module wildcard_name_filter import wnf_pkg::*; #(
    parameter int PATTERN_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // pattern / name beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int D  = PATTERN_DEPTH;
    localparam int LW = $clog2(D + 1);

    // ---------------------------------------------------------------- state
    logic [1:0]    filter_reg;
    logic [LW-1:0] len_reg,     len_next;
    logic [D:0]    act_reg,     act_next;   // active set while in a name
    logic [D:0]    start_reg,   start_next; // closure of the start position
    logic          started_reg, started_next;
    logic          restart_reg, restart_next;
    logic [1:0]    dot_reg,     dot_next;
    logic          ovf_reg,     ovf_next;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= TYPE_FILTER_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_TYPE_FILTER) begin
            filter_reg <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TYPE_FILTER)
            prdata = {30'd0, filter_reg};
    end

    // ---------------------------------------------------------------- input
    logic       acc;
    logic       can_push;
    logic       push;
    out_beat_t  res;

    assign s_ready = can_push;
    assign acc     = s_valid & s_ready;

    // pattern write point: a restart empties the pattern first
    logic [LW-1:0] eff_len;
    logic [D:0]    eff_start;
    logic          room;
    logic          pat_wr;

    assign eff_len   = restart_reg ? '0 : len_reg;
    assign eff_start = restart_reg ? (D+1)'(1) : start_reg;
    assign room      = eff_len < LW'(D);
    assign pat_wr    = acc && (s_data.operation == OP_PATTERN) && room;

    // ---------------------------------------------------------------- cells
    logic [7:0] sym;
    logic [D:0] cur;
    logic [D:0] fin;
    logic [D:0] used;
    link_t      link [0:D];

    assign sym     = fold_case(s_data.char_value);
    assign cur     = started_reg ? act_reg : start_reg;
    assign link[0] = '0;

    for (genvar i = 0; i < D; i++) begin : g_cell
        assign used[i] = LW'(i) < len_reg;

        wnf_cell u_cell (
            .aclk    (aclk),
            .we      (pat_wr && eff_len == LW'(i)),
            .wdata   (s_data.char_value),
            .sym     (sym),
            .act     (cur[i]),
            .used    (used[i]),
            .link_in (link[i]),
            .link_out(link[i+1]),
            .fin     (fin[i])
        );
    end

    // end cell: reached when a pattern of the full PATTERN_DEPTH is consumed
    assign used[D] = 1'b0;
    assign fin[D]  = link[D].fwd | link[D].carry;

    // ---------------------------------------------------------------- name side
    logic [1:0] dot_cur;
    logic [1:0] dot_upd;
    logic       kind_ok;
    logic       is_dots;

    assign dot_cur = started_reg ? dot_reg : DOT_EMPTY;

    always_comb begin
        if (dot_cur == DOT_EMPTY && s_data.char_value == CH_DOT)
            dot_upd = DOT_ONE;
        else if (dot_cur == DOT_ONE && s_data.char_value == CH_DOT)
            dot_upd = DOT_TWO;
        else
            dot_upd = DOT_OTHER;
    end

    assign is_dots = (dot_upd == DOT_ONE) || (dot_upd == DOT_TWO);

    always_comb begin
        case (filter_reg)
            FILT_ALL:  kind_ok = 1'b1;
            FILT_FILE: kind_ok = (s_data.entry_kind == KIND_FILE);
            FILT_DIR:  kind_ok = (s_data.entry_kind == KIND_DIR);
            default:   kind_ok = 1'b0;
        endcase
    end

    assign res.name_matches     = fin[len_reg];
    assign res.entry_accepted   = fin[len_reg] & ~is_dots & kind_ok;
    assign res.pattern_overflow = ovf_reg;

    assign push = acc && (s_data.operation == OP_NAME) && s_data.last;

    // ---------------------------------------------------------------- next state
    always_comb begin
        len_next     = len_reg;
        act_next     = act_reg;
        start_next   = start_reg;
        started_next = started_reg;
        restart_next = restart_reg;
        dot_next     = dot_reg;
        ovf_next     = ovf_reg;
        if (acc) begin
            unique case (s_data.operation)
                OP_PATTERN: begin
                    started_next = 1'b0;
                    restart_next = s_data.last;
                    ovf_next     = restart_reg ? 1'b0 : ovf_reg;
                    start_next   = eff_start;
                    len_next     = eff_len;
                    if (room) begin
                        len_next = eff_len + LW'(1);
                        // star appended right after the closure front extends it
                        for (int j = 1; j <= D; j++) begin
                            if (LW'(j) == eff_len + LW'(1) && eff_start[eff_len]
                                && s_data.char_value == CH_STAR)
                                start_next[j] = 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    started_next = 1'b0;
                    restart_next = 1'b1;
                    len_next     = '0;
                    ovf_next     = 1'b0;
                    start_next   = (D+1)'(1);
                end
                OP_NAME: begin
                    act_next     = fin;
                    dot_next     = dot_upd;
                    started_next = ~s_data.last;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            act_reg     <= (D+1)'(1);
            start_reg   <= (D+1)'(1);
            started_reg <= 1'b0;
            restart_reg <= 1'b1;
            dot_reg     <= DOT_EMPTY;
            ovf_reg     <= 1'b0;
        end else begin
            len_reg     <= len_next;
            act_reg     <= act_next;
            start_reg   <= start_next;
            started_reg <= started_next;
            restart_reg <= restart_next;
            dot_reg     <= dot_next;
            ovf_reg     <= ovf_next;
        end
    end

    // ---------------------------------------------------------------- output
    wnf_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(res),
        .can_push (can_push),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // ---------------------------------------------------------------- checks
    a_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg[0])
        else $error("start position dropped from start closure");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(D))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> len_reg == LW'(D))
        else $error("overflow flagged on a pattern that is not full");

    a_beyond_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_reg >> len_reg) <= (D+1)'(1))
        else $error("start closure reaches past the pattern end");

endmodule

`default_nettype wire

// File: tb/sv/wnf_match_checker.sv
// ============================================================================
// wnf_match_checker - result predictor and scoreboard for the name filter
// Follows the pattern and name beats and the type_filter register, works
// out the verdict of every finished name and compares it with m_data.
// ============================================================================

module wnf_match_checker import wnf_pkg::*; #(
    parameter int PATTERN_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_beat_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_beat_t   m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    output int unsigned      mismatches,
    output int unsigned      verdicts_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_TYPE_FILTER = {REG_TYPE_FILTER, 2'b00};

    logic [7:0]             pat_mem [PATTERN_DEPTH];
    int unsigned            pat_len;
    logic [PATTERN_DEPTH:0] live;       // active pattern positions, bit pat_len = end
    logic                   in_name;
    logic                   fresh_pat;  // next pattern beat starts a new pattern
    logic                   truncated;
    logic [1:0]             dot_st;
    logic [1:0]             filt;
    out_beat_t              verdict_q [$];
    int unsigned            bad;

    assign mismatches = bad;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
    endfunction

    // an active star also activates the position after it
    function automatic void spread_stars();
        for (int i = 0; i < pat_len; i++)
            if (live[i] && pat_mem[i] == CH_STAR)
                live[i + 1] = 1'b1;
    endfunction

    task automatic flag(input string msg);
        bad++;
        if (bad <= 10)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic predict_entry(input in_beat_t b);
        logic [PATTERN_DEPTH:0] nxt;
        logic [7:0]             u;
        logic                   hit, dotty, kind_ok;
        out_beat_t              v;
        case (b.operation)
            OP_PATTERN: begin
                in_name = 1'b0;
                if (fresh_pat) begin
                    pat_len   = 0;
                    truncated = 1'b0;
                end
                if (pat_len < PATTERN_DEPTH) begin
                    pat_mem[pat_len] = b.char_value;
                    pat_len++;
                end else begin
                    truncated = 1'b1;
                end
                fresh_pat = b.last;
            end
            OP_CLEAR: begin
                in_name   = 1'b0;
                pat_len   = 0;
                truncated = 1'b0;
                fresh_pat = 1'b1;
            end
            OP_NAME: begin
                if (!in_name) begin
                    live    = '0;
                    live[0] = 1'b1;
                    spread_stars();
                    dot_st  = DOT_EMPTY;
                    in_name = 1'b1;
                end
                u   = upcase(b.char_value);
                nxt = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (live[i]) begin
                        if (pat_mem[i] == CH_STAR)
                            nxt[i] = 1'b1;
                        else if (pat_mem[i] == CH_QMARK || upcase(pat_mem[i]) == u)
                            nxt[i + 1] = 1'b1;
                    end
                end
                live = nxt;
                spread_stars();
                if (dot_st == DOT_EMPTY && b.char_value == CH_DOT)
                    dot_st = DOT_ONE;
                else if (dot_st == DOT_ONE && b.char_value == CH_DOT)
                    dot_st = DOT_TWO;
                else
                    dot_st = DOT_OTHER;
                if (b.last) begin
                    hit   = live[pat_len];
                    dotty = (dot_st == DOT_ONE) || (dot_st == DOT_TWO);
                    case (filt)
                        FILT_ALL:  kind_ok = 1'b1;
                        FILT_FILE: kind_ok = (b.entry_kind == KIND_FILE);
                        FILT_DIR:  kind_ok = (b.entry_kind == KIND_DIR);
                        default:   kind_ok = 1'b0;
                    endcase
                    v.name_matches     = hit;
                    v.entry_accepted   = hit && !dotty && kind_ok;
                    v.pattern_overflow = truncated;
                    verdict_q.push_back(v);
                    in_name = 1'b0;
                end
            end
            default: ;  // spare opcode, no effect
        endcase
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            pat_len   = 0;
            live      = '0;
            live[0]   = 1'b1;
            in_name   = 1'b0;
            fresh_pat = 1'b1;
            truncated = 1'b0;
            dot_st    = DOT_EMPTY;
            filt      = TYPE_FILTER_RESET;
            verdict_q.delete();
        end else begin
            if (psel && penable && pready && paddr == ADDR_TYPE_FILTER) begin
                if (pwrite)
                    filt = pwdata[1:0];
                else if (prdata !== {30'd0, filt})
                    flag($sformatf("type_filter read: expected %h, got %h",
                                   {30'd0, filt}, prdata));
            end
            // results first: a name finished on this edge cannot show yet
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    flag($sformatf("unexpected result %b", m_data));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.name_matches !== want.name_matches ||
                        m_data.entry_accepted !== want.entry_accepted ||
                        m_data.pattern_overflow !== want.pattern_overflow)
                        flag($sformatf({"match/accept/overflow expected %b%b%b, ",
                                        "got %b%b%b"},
                                       want.name_matches, want.entry_accepted,
                                       want.pattern_overflow, m_data.name_matches,
                                       m_data.entry_accepted, m_data.pattern_overflow));
                end
            end
            if (s_valid && s_ready)
                predict_entry(s_data);
        end
        verdicts_due <= verdict_q.size();
    end

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top - testbench for wildcard_name_filter
// Feeds pattern, name, clear and spare beats under varying idle and stall
// patterns, steps type_filter through all its values between phases and
// leaves prediction and checking to wnf_match_checker.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wnf_pkg::*;

    localparam int          PATTERN_DEPTH = 32;
    localparam int          RANDOM_ITEMS  = 550;
    localparam int          PHASES        = 8;
    localparam int          DRAIN_TAIL    = 4;          // longer than the result latency
    localparam longint      TIMEOUT_NS    = 2_000_000;
    localparam logic [1:0]  OP_IGNORED    = 2'd3;       // spare opcode
    localparam logic [1:0]  KIND_OTHER    = 2'd2;
    localparam logic [1:0]  KIND_SPARE    = 2'd3;
    localparam logic [1:0]  FILT_NONE     = 2'd3;
    localparam logic [2:0]  ADDR_TYPE_FILTER = {REG_TYPE_FILTER, 2'b00};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int unsigned mismatches;
    int unsigned verdicts_due;

    // idle controls, percent per cycle
    int unsigned idle_pct;
    int unsigned stall_pct;

    // beats that reach the block's logic (spare opcodes excluded)
    int unsigned sent;

    // last full pattern sent, used to build names that can match
    logic [7:0] pat_q [$];
    // scratch word for the pattern or name about to go out
    logic [7:0] word_q [$];

    wildcard_name_filter #(
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wnf_match_checker #(
        .PATTERN_DEPTH(PATTERN_DEPTH)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .mismatches   (mismatches),
        .verdicts_due (verdicts_due)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Result side: stall_pct of the cycles hold m_ready low.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL wildcard_name_filter");
        $finish;
    end

    // One beat on the input channel. Any idle gap is taken before valid
    // rises; once raised, valid and payload hold until the beat is taken.
    // Called on the edge where the previous beat went through, so valid
    // gets only one update per edge.
    task automatic send(input in_beat_t b);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put(input logic [1:0] op, input logic [7:0] ch, input logic lst,
                       input logic [1:0] kind);
        in_beat_t b;
        b.operation  = op;
        b.char_value = ch;
        b.last       = lst;
        b.entry_kind = kind;
        if (op != OP_IGNORED)
            sent++;
        send(b);
    endtask

    // Drop valid and wait until every predicted verdict has come back.
    // verdicts_due is registered, hence the first wait. The tail covers
    // beats that produce no result but may still be in flight.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // APB write of type_filter, then a read back (checked by the checker).
    task automatic set_filter(input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TYPE_FILTER;
        pwdata  <= {30'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // back to setup, this time for the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Byte source biased toward the interesting cases: a few letters in
    // both cases, dots, bytes right around the a-z / A-Z boundaries, 0x00/0xFF,
    // fully random bytes, and (when wild) '*' and '?'.
    function automatic logic [7:0] rand_glyph(input bit wild);
        case ($urandom_range(wild ? 9 : 7))
            0, 1: return CH_LOW_A + 8'($urandom_range(2));
            2, 3: return CH_LOW_A - CASE_OFS + 8'($urandom_range(2));
            4:    return CH_DOT;
            5:    return 8'($urandom_range(255));
            6: begin
                case ($urandom_range(5))
                    0: return 8'h40;                // just below 'A'
                    1: return 8'h5B;                // just above 'Z'
                    2: return 8'h60;                // just below 'a'
                    3: return 8'h7B;                // just above 'z'
                    4: return CH_LOW_Z;
                    default: return CH_LOW_Z - CASE_OFS;
                endcase
            end
            7:    return $urandom_range(1) ? 8'h00 : 8'hFF;
            8:    return CH_STAR;
            default: return CH_QMARK;
        endcase
    endfunction

    // Send word_q with the given opcode; closed puts last on the final byte.
    task automatic emit_word(input logic [1:0] op, input bit closed);
        for (int i = 0; i < word_q.size(); i++)
            put(op, word_q[i], closed && (i == word_q.size() - 1),
                2'($urandom_range(3)));
    endtask

    // Build a name that should mostly fit pat_q: stars expand to 0..3
    // bytes, '?' to one byte, letters flip case at random.
    task automatic build_fitting_name();
        logic [7:0] low;
        word_q.delete();
        foreach (pat_q[i]) begin
            low = pat_q[i] | CASE_OFS;
            if (pat_q[i] == CH_STAR)
                repeat ($urandom_range(3)) word_q.push_back(rand_glyph(1'b0));
            else if (pat_q[i] == CH_QMARK)
                word_q.push_back(rand_glyph(1'b0));
            else if (low >= CH_LOW_A && low <= CH_LOW_Z && $urandom_range(1))
                word_q.push_back(pat_q[i] ^ CASE_OFS);
            else
                word_q.push_back(pat_q[i]);
        end
        if (word_q.size() == 0)
            word_q.push_back(rand_glyph(1'b0));
    endtask

    // Random traffic until the beat count reaches target. Mostly proper
    // pattern/name sequences; about one step in seven is noise: spare
    // opcodes, clears, names or patterns cut short.
    task automatic run_random(input int unsigned target);
        int unsigned r, n;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 20) begin
                // new pattern; some run past capacity, some are empty
                word_q.delete();
                n = $urandom_range(99);
                if (n < 6) begin
                    put(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                        2'($urandom_range(3)));
                    pat_q.delete();
                end else begin
                    n = (n < 18) ? $urandom_range(40, 30) : $urandom_range(8, 1);
                    repeat (n) word_q.push_back(rand_glyph(1'b1));
                    pat_q = word_q;
                    emit_word(OP_PATTERN, 1'b1);
                end
            end else if (r < 86) begin
                n = $urandom_range(99);
                if (n < 50) begin
                    build_fitting_name();
                end else if (n < 58) begin
                    // "." and ".." must never be accepted
                    word_q.delete();
                    word_q.push_back(CH_DOT);
                    if ($urandom_range(1))
                        word_q.push_back(CH_DOT);
                end else begin
                    word_q.delete();
                    repeat ($urandom_range(10, 1)) word_q.push_back(rand_glyph(1'b1));
                end
                emit_word(OP_NAME, 1'b1);
            end else begin
                word_q.delete();
                case ($urandom_range(3))
                    0: put(OP_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                           2'($urandom_range(3)));
                    1: begin
                        put(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            2'($urandom_range(3)));
                        pat_q.delete();
                    end
                    2: begin
                        // name left open: either continued or abandoned next
                        repeat ($urandom_range(3, 1)) word_q.push_back(rand_glyph(1'b0));
                        emit_word(OP_NAME, 1'b0);
                    end
                    default: begin
                        // pattern left open: the next pattern bytes extend it
                        repeat ($urandom_range(4, 1)) word_q.push_back(rand_glyph(1'b1));
                        emit_word(OP_PATTERN, 1'b0);
                    end
                endcase
            end
        end
    endtask

    initial begin
        int unsigned mode;
        logic [1:0]  filt;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, type_filter still at its reset value (files) ----
        // no pattern loaded yet: empty pattern matches nothing
        put(OP_NAME, "x", 1'b1, KIND_FILE);
        // spare opcode must be ignored
        put(OP_IGNORED, 8'hFF, 1'b1, KIND_SPARE);
        // "*" matches anything, but "." and ".." are still refused
        put(OP_PATTERN, CH_STAR, 1'b1, KIND_FILE);
        put(OP_NAME, CH_DOT, 1'b1, KIND_DIR);
        put(OP_NAME, CH_DOT, 1'b0, KIND_FILE);
        put(OP_NAME, CH_DOT, 1'b1, KIND_FILE);
        // case folding, '?' against a zero byte, 0xFF literal, unused kind
        put(OP_PATTERN, "a", 1'b0, KIND_FILE);
        put(OP_PATTERN, CH_QMARK, 1'b0, KIND_FILE);
        put(OP_PATTERN, 8'hFF, 1'b1, KIND_FILE);
        put(OP_NAME, "A", 1'b0, KIND_FILE);
        put(OP_NAME, 8'h00, 1'b0, KIND_FILE);
        put(OP_NAME, 8'hFF, 1'b1, KIND_SPARE);
        // a pattern beat in the middle of a name abandons that name
        put(OP_NAME, "a", 1'b0, KIND_FILE);
        put(OP_PATTERN, CH_STAR, 1'b0, KIND_FILE);
        put(OP_PATTERN, "Z", 1'b1, KIND_FILE);
        put(OP_NAME, "z", 1'b1, KIND_FILE);
        // clear gives no result and leaves an empty pattern
        put(OP_CLEAR, 8'h00, 1'b0, KIND_FILE);
        put(OP_NAME, "z", 1'b1, KIND_DIR);
        // single '?' matches a lone zero byte; kind "other" fails the filter
        put(OP_PATTERN, CH_QMARK, 1'b1, KIND_FILE);
        put(OP_NAME, 8'h00, 1'b1, KIND_OTHER);

        // ---- random phases: new filter setting and idle mix each time ----
        // settle() between phases also gives the full pause with every
        // result returned before the next beat.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 4)
                0:       filt = FILT_ALL;
                1:       filt = FILT_NONE;
                2:       filt = FILT_DIR;
                default: filt = FILT_FILE;
            endcase
            set_filter(filt);
            mode = (ph + ph / 4) % 4;
            case (mode)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default: begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            @(posedge aclk);
            run_random(sent + RANDOM_ITEMS / PHASES);
        end

        settle();
        if (mismatches == 0)
            $display("PASS wildcard_name_filter");
        else
            $display("FAIL wildcard_name_filter");
        $finish;
    end

endmodule
